// ===== hw/rtl/tvms_pkg.sv =====
`default_nettype none

package tvms_pkg;

  // Field widths and counts
  localparam int DISP_WIDTH = 16;
  localparam int NUM_DISP   = 6;
  localparam int NUM_STRESS = 3;
  localparam int MASK_W     = NUM_DISP;
  localparam int OUT_W      = 51;

  // |coefficient row sum| is at most 720, below 2^10
  localparam int STRESS_W = DISP_WIDTH + 10;
  localparam int PROD_W   = 2 * STRESS_W;
  localparam int SUM_W    = PROD_W + 3;

  // Stream packing
  localparam int MASK_LSB   = NUM_DISP * DISP_WIDTH;
  localparam int IN_DATA_W  = ((MASK_LSB + MASK_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((2 * OUT_W + 7) / 8) * 8;
  localparam int OUT_PAD_W  = OUT_DATA_W - 2 * OUT_W;

  // Any |stress| above this pushes the quadratic form past the output range
  localparam longint SAT_LIMIT = longint'(1) << 26;

  localparam logic [OUT_W-1:0] OUT_MAX = '1;

  // Strain-stress matrix, rows s0..s2, columns disp_0..disp_5
  localparam int COEF [NUM_STRESS][NUM_DISP] = '{
    '{-240, -120, 240,  0,  0, 120},
    '{-120, -240, 120,  0,  0, 240},
    '{ -60,  -60,   0, 60, 60,   0}
  };

  typedef logic signed [DISP_WIDTH-1:0] disp_t;
  typedef disp_t [NUM_DISP-1:0]         disp_vec_t;
  typedef logic signed [STRESS_W-1:0]   stress_t;
  typedef stress_t [NUM_STRESS-1:0]     stress_vec_t;
  typedef logic signed [PROD_W-1:0]     prod_t;
  typedef logic signed [SUM_W-1:0]      sum_t;
  typedef logic [OUT_W-1:0]             result_t;

  // Per-stage control travelling alongside the payload
  typedef struct packed {
    logic valid;
    logic last;
  } ctl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tvms_stress.sv =====
`default_nettype none

module tvms_stress import tvms_pkg::*; (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         en_i,
  input  ctl_t        ctl_i,
  input  disp_vec_t   disp_i,
  output ctl_t        ctl_o,
  output stress_vec_t stress_o
);

  ctl_t        ctl_q;
  stress_vec_t stress_q;
  stress_vec_t stress_d;

  // Matrix-vector product against the constant coefficients
  always_comb begin
    stress_t acc;
    for (int i = 0; i < NUM_STRESS; i++) begin
      acc = '0;
      for (int j = 0; j < NUM_DISP; j++) begin
        acc = acc + stress_t'(COEF[i][j]) * stress_t'(disp_i[j]);
      end
      stress_d[i] = acc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (en_i) begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      stress_q <= stress_d;
    end
  end

  assign ctl_o    = ctl_q;
  assign stress_o = stress_q;

endmodule

`default_nettype wire

// ===== hw/rtl/tvms_square.sv =====
`default_nettype none

module tvms_square import tvms_pkg::*; (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         en_i,
  input  ctl_t        ctl_i,
  input  stress_vec_t stress_i,
  output ctl_t        ctl_o,
  output result_t     q_o
);

  // Product stage
  ctl_t    prd_ctl_q;
  logic    prd_sat_q;
  logic    prd_sat_d;
  prod_t   p_aa_q, p_bb_q, p_ab_q, p_cc_q;
  prod_t   p_aa_d, p_bb_d, p_ab_d, p_cc_d;

  // Sum stage
  ctl_t    sum_ctl_q;
  result_t q_q;
  result_t q_d;
  sum_t    sum;

  always_comb begin
    stress_t sa;
    stress_t sb;
    stress_t sc;
    sa = stress_i[0];
    sb = stress_i[1];
    sc = stress_i[2];
    p_aa_d = sa * sa;
    p_bb_d = sb * sb;
    p_ab_d = sa * sb;
    p_cc_d = sc * sc;
    prd_sat_d = 1'b0;
    for (int i = 0; i < NUM_STRESS; i++) begin
      if (longint'(stress_i[i]) > SAT_LIMIT || longint'(stress_i[i]) < -SAT_LIMIT) begin
        prd_sat_d = 1'b1;
      end
    end
  end

  // s0^2 + s1^2 + s0*s1 + 3*s2^2, clamped to the output range
  assign sum = sum_t'(p_aa_q) + sum_t'(p_bb_q) + sum_t'(p_ab_q)
             + sum_t'(p_cc_q) + (sum_t'(p_cc_q) <<< 1);

  always_comb begin
    if (prd_sat_q || sum > sum_t'(OUT_MAX)) begin
      q_d = OUT_MAX;
    end else begin
      q_d = sum[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prd_ctl_q <= '0;
      sum_ctl_q <= '0;
    end else if (en_i) begin
      prd_ctl_q <= ctl_i;
      sum_ctl_q <= prd_ctl_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prd_sat_q <= prd_sat_d;
      p_aa_q    <= p_aa_d;
      p_bb_q    <= p_bb_d;
      p_ab_q    <= p_ab_d;
      p_cc_q    <= p_cc_d;
      q_q       <= q_d;
    end
  end

  assign ctl_o = sum_ctl_q;
  assign q_o   = q_q;

endmodule

`default_nettype wire

// ===== hw/rtl/tvms_peak.sv =====
`default_nettype none

module tvms_peak import tvms_pkg::*; (
  input  wire     clk_i,
  input  wire     rst_ni,
  input  wire     en_i,
  input  ctl_t    ctl_i,
  input  result_t q_i,
  output ctl_t    ctl_o,
  output result_t q_o,
  output result_t max_o
);

  ctl_t    ctl_q;
  result_t q_q;
  result_t out_max_q;
  result_t max_q;
  result_t max_d;

  // Running maximum including the current item
  assign max_d = (q_i > max_q) ? q_i : max_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
      max_q <= '0;
    end else if (en_i) begin
      ctl_q <= ctl_i;
      if (ctl_i.valid) begin
        // cleared once the last item of a structure has been folded in
        max_q <= ctl_i.last ? '0 : max_d;
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      q_q       <= q_i;
      out_max_q <= max_d;
    end
  end

  assign ctl_o = ctl_q;
  assign q_o   = q_q;
  assign max_o = out_max_q;

endmodule

`default_nettype wire

// ===== hw/rtl/triangle_von_mises_stress.sv =====
// Path: an input transfer loads the input register, then passes the stress, product,
// sum and output register stages in order; it is held in place while stalled.
// Throughput: one triangle per cycle; the five-stage pipeline advances as a whole
// whenever the output register is empty or its result is being taken.
// Reset: asynchronous, active low; empties the pipeline and clears the running max.
`default_nettype none

module triangle_von_mises_stress import tvms_pkg::*; (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  // disp_0..disp_5 (16 bits each, signed), free_mask (6 bits), zero pad
  input  wire  [IN_DATA_W-1:0]  s_axis_tdata_i,
  input  wire                   s_axis_tlast_i,   // is_last
  input  wire                   s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // squared_stress (51 bits), running_max (51 bits), zero pad
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o,
  output logic                  m_axis_tlast_o,   // last_out
  output logic                  m_axis_tvalid_o,
  input  wire                   m_axis_tready_i
);

  logic        en;
  ctl_t        in_ctl_d;
  ctl_t        in_ctl_q;
  disp_vec_t   disp_d;
  disp_vec_t   disp_q;
  ctl_t        str_ctl;
  stress_vec_t stress;
  ctl_t        sq_ctl;
  result_t     sq_q;
  ctl_t        out_ctl;
  result_t     out_q;
  result_t     out_max;

  // Whole pipeline moves when the output register can take a new entry
  assign en              = !out_ctl.valid || m_axis_tready_i;
  assign s_axis_tready_o = en;

  // Input register: fixed displacements are forced to zero here
  always_comb begin
    for (int j = 0; j < NUM_DISP; j++) begin
      disp_d[j] = s_axis_tdata_i[MASK_LSB + j] ?
                  s_axis_tdata_i[j*DISP_WIDTH +: DISP_WIDTH] : '0;
    end
    in_ctl_d.valid = s_axis_tvalid_i;
    in_ctl_d.last  = s_axis_tlast_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ctl_q <= '0;
    end else if (en) begin
      in_ctl_q <= in_ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      disp_q <= disp_d;
    end
  end

  tvms_stress u_stress (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .ctl_i    (in_ctl_q),
    .disp_i   (disp_q),
    .ctl_o    (str_ctl),
    .stress_o (stress)
  );

  tvms_square u_square (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .ctl_i    (str_ctl),
    .stress_i (stress),
    .ctl_o    (sq_ctl),
    .q_o      (sq_q)
  );

  tvms_peak u_peak (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .ctl_i  (sq_ctl),
    .q_i    (sq_q),
    .ctl_o  (out_ctl),
    .q_o    (out_q),
    .max_o  (out_max)
  );

  assign m_axis_tvalid_o = out_ctl.valid;
  assign m_axis_tlast_o  = out_ctl.last;
  assign m_axis_tdata_o  = {OUT_PAD_W'(0), out_max, out_q};

  // Occupancy tracking for the checks below
  logic       in_xfer;
  logic       out_xfer;
  logic [2:0] inflight_q;

  assign in_xfer  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_xfer = m_axis_tvalid_o && m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else begin
      inflight_q <= inflight_q + 3'(in_xfer) - 3'(out_xfer);
    end
  end

  // Running max never falls below the stress it is reported with
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (out_max >= out_q))
    else $error("running max below reported stress");

  // No more than five transfers in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    inflight_q <= 3'd5)
    else $error("pipeline holds more items than stages");

  // A result only appears for an accepted item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (inflight_q != 3'd0))
    else $error("result without an accepted item");

  // Within a structure the running max does not decrease
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($past(out_xfer && !m_axis_tlast_o) && out_xfer) |-> (out_max >= $past(out_max)))
    else $error("running max decreased within a structure");

endmodule

`default_nettype wire
